### rtl/vapc_pkg.sv
// Shared types, constants and field positions for the vent actuator position controller.
package vapc_pkg;

  localparam int TICKS_PER_UPDATE_DEF = 6;
  localparam int TICKS_PER_AUTO_DEF   = 600;
  localparam int FULL_SCALE_DEF       = 1000;

  localparam int STEP_NUM        = 600;
  localparam int STEP_W          = 10;
  localparam int TRAVEL_W        = 12;
  localparam int BAND_W          = 8;
  localparam int SECS_W          = 16;
  localparam int TIMER_W         = 20;
  localparam int MOVE_CNT_W      = 5;
  localparam int MOVE_SAVE_LIMIT = 20;
  localparam int PCT_MAX         = 100;
  localparam int OUT_OPEN_W      = 10;

  localparam logic signed [BAND_W-1:0] TEMP_MIN   = -8'sd100;
  localparam logic signed [BAND_W-1:0] TEMP_MAX   = 8'sd100;
  localparam logic signed [BAND_W-1:0] TEMP_RESET = 8'sd15;
  localparam logic signed [BAND_W-1:0] BAND_LOW_RESET  = 8'sd15;
  localparam logic signed [BAND_W-1:0] BAND_HIGH_RESET = 8'sd20;
  localparam logic [TRAVEL_W-1:0]      TRAVEL_RESET    = 12'd600;

  // Input beat layout.
  localparam int IN_W        = 40;
  localparam int IN_OP_LSB   = 0;
  localparam int IN_MASK_LSB = 3;
  localparam int IN_SECS_LSB = 5;
  localparam int IN_MODE_LSB = 21;
  localparam int IN_TEMP_LSB = 22;
  localparam int IN_PCT_LSB  = 30;

  // Output beat layout.
  localparam int OUT_W          = 32;
  localparam int OUT_FWD_A      = 0;
  localparam int OUT_REV_A      = 1;
  localparam int OUT_FWD_B      = 2;
  localparam int OUT_REV_B      = 3;
  localparam int OUT_MOT_A_LSB  = 4;
  localparam int OUT_MOT_B_LSB  = 6;
  localparam int OUT_OPEN_A_LSB = 8;
  localparam int OUT_OPEN_B_LSB = 18;
  localparam int OUT_AUTO_A     = 28;
  localparam int OUT_AUTO_B     = 29;
  localparam int OUT_SAVE_A     = 30;
  localparam int OUT_SAVE_B     = 31;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [2:0] {
    OP_TICK, OP_FWD, OP_REV, OP_STOP, OP_SET_MODE, OP_TOGGLE_MODE, OP_SET_TEMP, OP_SET_OPENING
  } opcode_t;

  typedef enum logic [1:0] {
    MOT_STOP, MOT_FWD, MOT_REV
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_LOW_A, CFG_BAND_HIGH_A, CFG_TRAVEL_A,
    CFG_BAND_LOW_B, CFG_BAND_HIGH_B, CFG_TRAVEL_B
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE, S_DIV, S_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic apply;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } ctl_sts_t;

endpackage

### rtl/vapc_div.sv
// Two-lane restoring divider that forms the per-update opening step 600 / travel time.
module vapc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [vapc_pkg::TRAVEL_W-1:0]   travel_a,
  input  logic [vapc_pkg::TRAVEL_W-1:0]   travel_b,
  output logic                            busy,
  output logic [vapc_pkg::STEP_W-1:0]     step_a,
  output logic [vapc_pkg::STEP_W-1:0]     step_b
);
  import vapc_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEP_W-1:0]   dvd_r, dvd_nxt;
  logic [TRAVEL_W-1:0] rem_r [2];
  logic [TRAVEL_W-1:0] rem_nxt [2];
  logic [STEP_W-1:0]   quo_r [2];
  logic [STEP_W-1:0]   quo_nxt [2];
  logic [TRAVEL_W-1:0] dvs [2];

  // A zero travel time is taken as one second.
  assign dvs[0] = (travel_a == '0) ? TRAVEL_W'(1) : travel_a;
  assign dvs[1] = (travel_b == '0) ? TRAVEL_W'(1) : travel_b;

  always_comb begin
    logic [TRAVEL_W:0] rem_sh;
    logic [TRAVEL_W:0] diff;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_sh   = '0;
    diff     = '0;
    for (int v = 0; v < 2; v++) begin
      rem_nxt[v] = rem_r[v];
      quo_nxt[v] = quo_r[v];
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEP_W);
      dvd_nxt  = STEP_W'(STEP_NUM);
      for (int v = 0; v < 2; v++) begin
        rem_nxt[v] = '0;
        quo_nxt[v] = '0;
      end
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
      dvd_nxt  = {dvd_r[STEP_W-2:0], 1'b0};
      for (int v = 0; v < 2; v++) begin
        rem_sh = {rem_r[v], dvd_r[STEP_W-1]};
        diff   = rem_sh - {1'b0, dvs[v]};
        if (rem_sh >= {1'b0, dvs[v]}) begin
          rem_nxt[v] = diff[TRAVEL_W-1:0];
          quo_nxt[v] = {quo_r[v][STEP_W-2:0], 1'b1};
        end else begin
          rem_nxt[v] = rem_sh[TRAVEL_W-1:0];
          quo_nxt[v] = {quo_r[v][STEP_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    for (int v = 0; v < 2; v++) begin
      rem_r[v] <= rem_nxt[v];
      quo_r[v] <= quo_nxt[v];
    end
  end

  assign busy   = busy_r;
  assign step_a = quo_r[0];
  assign step_b = quo_r[1];

endmodule

### rtl/vapc_dp.sv
// Datapath: configuration, vent state, tick dividers and the per-item update of both vents.
module vapc_dp #(
  parameter int TICKS_PER_UPDATE = vapc_pkg::TICKS_PER_UPDATE_DEF,
  parameter int TICKS_PER_AUTO   = vapc_pkg::TICKS_PER_AUTO_DEF,
  parameter int FULL_SCALE       = vapc_pkg::FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vapc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vapc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [vapc_pkg::IN_W-1:0]         in_tdata,
  input  vapc_pkg::ctl_cmd_t                cmd,
  output vapc_pkg::ctl_sts_t                sts,
  output logic [vapc_pkg::OUT_W-1:0]        out_tdata
);
  import vapc_pkg::*;

  localparam int UPD_W  = $clog2(TICKS_PER_UPDATE + 1);
  localparam int AUTO_W = $clog2(TICKS_PER_AUTO + 1);
  localparam int OPEN_W = $clog2(FULL_SCALE + 1);
  localparam int SUM_W  = ((OPEN_W > STEP_W) ? OPEN_W : STEP_W) + 2;
  localparam logic [OPEN_W-1:0] FS_V = OPEN_W'(FULL_SCALE);

  // Configuration registers.
  logic signed [BAND_W-1:0] band_low_r  [2];
  logic signed [BAND_W-1:0] band_high_r [2];
  logic [TRAVEL_W-1:0]      travel_r    [2];

  // Latched item.
  opcode_t                  op_r;
  logic [1:0]               mask_r;
  logic [SECS_W-1:0]        secs_r;
  logic                     mode_r;
  logic signed [BAND_W-1:0] temp_r;
  logic signed [BAND_W-1:0] pct_r;

  // Vent state.
  motion_t                  mot_r   [2];
  motion_t                  mot_nxt [2];
  logic                     auto_r   [2];
  logic                     auto_nxt [2];
  logic [OPEN_W-1:0]        open_r   [2];
  logic [OPEN_W-1:0]        open_nxt [2];
  logic signed [BAND_W-1:0] tstore_r   [2];
  logic signed [BAND_W-1:0] tstore_nxt [2];
  logic [TIMER_W-1:0]       tmr_r   [2];
  logic [TIMER_W-1:0]       tmr_nxt [2];
  logic                     act_r   [2];
  logic                     act_nxt [2];
  logic [MOVE_CNT_W-1:0]    mcnt_r   [2];
  logic [MOVE_CNT_W-1:0]    mcnt_nxt [2];
  logic                     pf_r   [2];
  logic                     pf_nxt [2];
  logic                     pr_r   [2];
  logic                     pr_nxt [2];
  logic                     save_r   [2];
  logic                     save_nxt [2];
  logic [UPD_W-1:0]         upd_div_r, upd_div_nxt;
  logic [AUTO_W-1:0]        auto_div_r, auto_div_nxt;

  logic [STEP_W-1:0]        step [2];
  logic                     div_busy;
  logic                     upd_hit;
  logic                     auto_hit;
  logic [TIMER_W-1:0]       run_ticks;
  logic [SUM_W-1:0]         pct_x10;
  logic [OPEN_W-1:0]        pct_open;

  vapc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .travel_a (travel_r[0]),
    .travel_b (travel_r[1]),
    .busy     (div_busy),
    .step_a   (step[0]),
    .step_b   (step[1])
  );

  assign upd_hit  = ({1'b0, upd_div_r} + 1'b1) >= (UPD_W + 1)'(TICKS_PER_UPDATE);
  assign auto_hit = ({1'b0, auto_div_r} + 1'b1) >= (AUTO_W + 1)'(TICKS_PER_AUTO);

  assign sts.need_div = (opcode_t'(in_tdata[IN_OP_LSB +: 3]) == OP_TICK) && upd_hit;
  assign sts.div_busy = div_busy;

  assign run_ticks = TIMER_W'({secs_r, 3'b000}) + TIMER_W'({secs_r, 1'b0});
  assign pct_x10   = SUM_W'({pct_r[6:0], 3'b000}) + SUM_W'({pct_r[6:0], 1'b0});
  assign pct_open  = (pct_x10 > SUM_W'(FULL_SCALE)) ? FS_V : pct_x10[OPEN_W-1:0];

  always_comb begin
    motion_t            m;
    logic [OPEN_W-1:0]  o;
    logic [SUM_W-1:0]   sum;
    logic [MOVE_CNT_W-1:0] mc;
    logic [TIMER_W-1:0] tmr;
    logic               act;
    logic               s;
    m   = MOT_STOP;
    o   = '0;
    sum = '0;
    mc  = '0;
    tmr = '0;
    act = 1'b0;
    s   = 1'b0;
    upd_div_nxt  = upd_div_r;
    auto_div_nxt = auto_div_r;
    for (int v = 0; v < 2; v++) begin
      mot_nxt[v]    = mot_r[v];
      auto_nxt[v]   = auto_r[v];
      open_nxt[v]   = open_r[v];
      tstore_nxt[v] = tstore_r[v];
      tmr_nxt[v]    = tmr_r[v];
      act_nxt[v]    = act_r[v];
      mcnt_nxt[v]   = mcnt_r[v];
      pf_nxt[v]     = pf_r[v];
      pr_nxt[v]     = pr_r[v];
      save_nxt[v]   = save_r[v];
    end
    if (cmd.apply) begin
      if (op_r == OP_TICK) begin
        upd_div_nxt  = upd_hit ? '0 : upd_div_r + 1'b1;
        auto_div_nxt = auto_hit ? '0 : auto_div_r + 1'b1;
        for (int v = 0; v < 2; v++) begin
          m   = mot_r[v];
          o   = open_r[v];
          mc  = mcnt_r[v];
          tmr = tmr_r[v];
          act = act_r[v];
          s   = 1'b0;
          // Run timer; expiry acts as a stop command.
          if (act) begin
            if (tmr != '0) tmr = tmr - 1'b1;
            if (tmr == '0) begin
              act = 1'b0;
              if (!auto_r[v]) begin
                m = MOT_STOP;
                s = 1'b1;
              end
            end
          end
          if (upd_hit) begin
            if (m == MOT_FWD) begin
              sum = SUM_W'(o) + SUM_W'(step[v]);
              mc  = mc + 1'b1;
              o   = (sum >= SUM_W'(FULL_SCALE)) ? FS_V : sum[OPEN_W-1:0];
            end else if (m == MOT_REV) begin
              mc = mc + 1'b1;
              if (SUM_W'(step[v]) >= SUM_W'(o)) begin
                o = '0;
              end else begin
                sum = SUM_W'(o) - SUM_W'(step[v]);
                o   = sum[OPEN_W-1:0];
              end
            end
            if (mc > MOVE_CNT_W'(MOVE_SAVE_LIMIT)) begin
              s  = 1'b1;
              mc = '0;
            end
          end
          if (auto_hit && auto_r[v]) begin
            if (tstore_r[v] >= band_low_r[v] && tstore_r[v] <= band_high_r[v]) begin
              m = MOT_STOP;
            end else if (tstore_r[v] < band_low_r[v]) begin
              m = MOT_FWD;
            end else begin
              m = MOT_REV;
            end
          end
          // Drive the pins and stop at the end stops.
          pf_nxt[v] = 1'b1;
          pr_nxt[v] = 1'b1;
          if (m == MOT_FWD) begin
            if (o < FS_V) pf_nxt[v] = 1'b0;
            else          m = MOT_STOP;
          end else if (m == MOT_REV) begin
            if (o != '0) pr_nxt[v] = 1'b0;
            else         m = MOT_STOP;
          end
          mot_nxt[v]  = m;
          open_nxt[v] = o;
          mcnt_nxt[v] = mc;
          tmr_nxt[v]  = tmr;
          act_nxt[v]  = act;
          save_nxt[v] = s;
        end
      end else begin
        for (int v = 0; v < 2; v++) begin
          save_nxt[v] = 1'b0;
          if (mask_r[v]) begin
            case (op_r)
              OP_FWD: begin
                if (open_r[v] < FS_V && !auto_r[v]) mot_nxt[v] = MOT_FWD;
                tmr_nxt[v] = run_ticks;
                act_nxt[v] = 1'b1;
              end
              OP_REV: begin
                if (open_r[v] != '0 && !auto_r[v]) mot_nxt[v] = MOT_REV;
                tmr_nxt[v] = run_ticks;
                act_nxt[v] = 1'b1;
              end
              OP_STOP: begin
                if (!auto_r[v]) begin
                  mot_nxt[v]  = MOT_STOP;
                  save_nxt[v] = 1'b1;
                end
              end
              OP_SET_MODE:    auto_nxt[v] = mode_r;
              OP_TOGGLE_MODE: auto_nxt[v] = !auto_r[v];
              OP_SET_TEMP: begin
                if (temp_r >= TEMP_MIN && temp_r <= TEMP_MAX) tstore_nxt[v] = temp_r;
              end
              OP_SET_OPENING: begin
                if (!pct_r[BAND_W-1] && pct_r[6:0] <= 7'(PCT_MAX)) open_nxt[v] = pct_open;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 2; v++) begin
        band_low_r[v]  <= BAND_LOW_RESET;
        band_high_r[v] <= BAND_HIGH_RESET;
        travel_r[v]    <= TRAVEL_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BAND_LOW_A:  band_low_r[0]  <= cfg_wdata[BAND_W-1:0];
        CFG_BAND_HIGH_A: band_high_r[0] <= cfg_wdata[BAND_W-1:0];
        CFG_TRAVEL_A:    travel_r[0]    <= cfg_wdata[TRAVEL_W-1:0];
        CFG_BAND_LOW_B:  band_low_r[1]  <= cfg_wdata[BAND_W-1:0];
        CFG_BAND_HIGH_B: band_high_r[1] <= cfg_wdata[BAND_W-1:0];
        CFG_TRAVEL_B:    travel_r[1]    <= cfg_wdata[TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_tdata[IN_OP_LSB +: 3]);
      mask_r <= in_tdata[IN_MASK_LSB +: 2];
      secs_r <= in_tdata[IN_SECS_LSB +: SECS_W];
      mode_r <= in_tdata[IN_MODE_LSB];
      temp_r <= in_tdata[IN_TEMP_LSB +: BAND_W];
      pct_r  <= in_tdata[IN_PCT_LSB +: BAND_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 2; v++) begin
        mot_r[v]    <= MOT_STOP;
        auto_r[v]   <= 1'b0;
        open_r[v]   <= '0;
        tstore_r[v] <= TEMP_RESET;
        tmr_r[v]    <= '0;
        act_r[v]    <= 1'b0;
        mcnt_r[v]   <= '0;
        pf_r[v]     <= 1'b1;
        pr_r[v]     <= 1'b1;
        save_r[v]   <= 1'b0;
      end
      upd_div_r  <= '0;
      auto_div_r <= '0;
    end else begin
      for (int v = 0; v < 2; v++) begin
        mot_r[v]    <= mot_nxt[v];
        auto_r[v]   <= auto_nxt[v];
        open_r[v]   <= open_nxt[v];
        tstore_r[v] <= tstore_nxt[v];
        tmr_r[v]    <= tmr_nxt[v];
        act_r[v]    <= act_nxt[v];
        mcnt_r[v]   <= mcnt_nxt[v];
        pf_r[v]     <= pf_nxt[v];
        pr_r[v]     <= pr_nxt[v];
        save_r[v]   <= save_nxt[v];
      end
      upd_div_r  <= upd_div_nxt;
      auto_div_r <= auto_div_nxt;
    end
  end

  // The vent state registers double as the result register: they change only
  // when a result is loaded into an empty or draining output slot.
  logic [OPEN_W+OUT_OPEN_W-1:0] open_ext [2];
  assign open_ext[0] = {{OUT_OPEN_W{1'b0}}, open_r[0]};
  assign open_ext[1] = {{OUT_OPEN_W{1'b0}}, open_r[1]};

  assign out_tdata = {save_r[1], save_r[0], auto_r[1], auto_r[0],
                      open_ext[1][OUT_OPEN_W-1:0], open_ext[0][OUT_OPEN_W-1:0],
                      mot_r[1], mot_r[0], pr_r[1], pf_r[1], pr_r[0], pf_r[0]};

endmodule

### rtl/vapc_ctrl.sv
// Controller: sequences accept, step division and apply, and owns the result valid flag.
module vapc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  vapc_pkg::ctl_sts_t sts,
  output vapc_pkg::ctl_cmd_t cmd
);
  import vapc_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = sts.need_div ? S_DIV : S_APPLY;
      S_DIV:   if (!sts.div_busy) state_nxt = S_APPLY;
      S_APPLY: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.apply     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load      = in_tvalid;
        cmd.div_start = in_tvalid && sts.need_div;
      end
      S_APPLY: begin
        cmd.apply = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/vent_actuator_position_controller.sv
// Top level of the two-vent actuator position controller.
// Commands and plain ticks go from the input beat through the apply state to the result; a
// tick that moves the openings also waits for the 10-step divider forming 600 / travel time.
// Items are worked one at a time: no new beat is taken until the current one is applied.
// A finished result waits in the output register while the next beat is taken.
// Reset: synchronous, active low; clears motion, mode, openings, timers and dividers at once.
module vent_actuator_position_controller #(
  parameter int TICKS_PER_UPDATE = vapc_pkg::TICKS_PER_UPDATE_DEF,
  parameter int TICKS_PER_AUTO   = vapc_pkg::TICKS_PER_AUTO_DEF,
  parameter int FULL_SCALE       = vapc_pkg::FULL_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode, vent_mask, run_seconds, mode_auto, temperature_in, opening_percent, zero pad
  input  logic [vapc_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fwd_pin_n_a, rev_pin_n_a, fwd_pin_n_b, rev_pin_n_b, motion_a, motion_b,
  // opening_a, opening_b, auto_a, auto_b, save_a, save_b
  output logic [vapc_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [vapc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vapc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vapc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  vapc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  vapc_dp #(
    .TICKS_PER_UPDATE (TICKS_PER_UPDATE),
    .TICKS_PER_AUTO   (TICKS_PER_AUTO),
    .FULL_SCALE       (FULL_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

### rtl/vapc_chk.sv
// Port-level checker for the vent actuator position controller, with its bind.
module vapc_chk #(
  parameter int FULL_SCALE = vapc_pkg::FULL_SCALE_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vapc_pkg::OUT_W-1:0]      out_tdata
);
  import vapc_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Items are worked one at a time: no beat is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken while an item is in progress");

  // A motor is never driven both ways.
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_FWD_A] || out_tdata[OUT_REV_A]) &&
                   (out_tdata[OUT_FWD_B] || out_tdata[OUT_REV_B]))
    else $error("forward and reverse pins both active");

  // Openings stay within full scale.
  a_open_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_OPEN_A_LSB +: OUT_OPEN_W] <= FULL_SCALE) &&
                   (out_tdata[OUT_OPEN_B_LSB +: OUT_OPEN_W] <= FULL_SCALE))
    else $error("opening beyond full scale");

endmodule

bind vent_actuator_position_controller vapc_chk #(.FULL_SCALE(FULL_SCALE)) u_vapc_chk (.*);
